[rtl/core/cslot_pkg.sv]
// package for the contiguous slot allocator: payload types and defaults
package cslot_pkg;

  localparam int SLOTS_DEFAULT = 128;
  localparam int FIELD_W       = 7;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [FIELD_W-1:0] block_size;
    logic [FIELD_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] head_slot;
    logic               forced;
    logic [FIELD_W-1:0] freed_count;
  } out_t;

endpackage

[rtl/core/contiguous_slot_allocator_unit.sv]
// first-fit contiguous slot allocator over a table memory with a registered read port
//
//   channel | handshake          | payload          | transaction taken when
//   --------+--------------------+------------------+------------------------------
//   input   | start / busy       | in_data (in_t)   | start high and busy low
//   result  | out_valid (strobe) | out_data (out_t) | the edge ending the strobe cycle
//
// allocate: one table read per scan cycle, then one write per block slot, then the
//   result strobe
// free: one table read, one write per cleared slot, then the result strobe
// zero-size allocate and out-of-range free answer on the cycle after acceptance
// after reset a clearing pass writes every entry with busy high
// the result strobe cannot be stalled; busy holds off new transactions while working
module contiguous_slot_allocator_unit #(
  parameter int SLOTS = cslot_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  cslot_pkg::in_t in_data,
  output logic           out_valid,
  output cslot_pkg::out_t out_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CW    = ($clog2(SLOTS + 1) > 8) ? $clog2(SLOTS + 1) : 8;
  localparam int FW    = cslot_pkg::FIELD_W;

  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [CW-1:0] LAST_C  = CW'(SLOTS - 1);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_WRITE
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       size_r;
  logic [CW-1:0]       limit_r;
  logic [CW-1:0]       scan_r;
  logic [CW-1:0]       run_r;
  logic [CW-1:0]       ptr_r;
  logic [CW-1:0]       cnt_r;
  logic                first_r;
  logic [FW-1:0]       head_val_r;
  logic [FW-1:0]       fill_val_r;
  logic                out_valid_r;
  cslot_pkg::out_t     out_r;
  cslot_pkg::out_t     res_r;

  logic [FW-1:0]       mem [SLOTS];
  logic [FW-1:0]       rd_data_r;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [FW-1:0]       mem_wdata;

  logic [CW-1:0]       req_size;
  logic [CW-1:0]       req_slot;
  logic [CW-1:0]       scan_nxt;
  logic [CW-1:0]       rd_ext;
  logic [CW-1:0]       room;
  logic [CW-1:0]       free_n;
  logic [CW-1:0]       forced_head;
  logic                accept;

  assign accept      = start && (state_r == S_IDLE);
  assign req_size    = (CW'(in_data.block_size) > SLOTS_C) ? SLOTS_C : CW'(in_data.block_size);
  assign req_slot    = CW'(in_data.slot);
  assign scan_nxt    = scan_r + ONE_C;
  assign rd_ext      = CW'(rd_data_r);
  assign room        = SLOTS_C - ptr_r;
  assign free_n      = (rd_ext < room) ? rd_ext : room;
  assign forced_head = SLOTS_C - size_r;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = ptr_r[IDX_W-1:0];
    mem_wdata = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_data.cmd == cslot_pkg::CMD_ALLOC) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
        end else if (accept && req_slot < SLOTS_C) begin
          mem_re    = 1'b1;
          mem_raddr = req_slot[IDX_W-1:0];
        end
      end
      S_SCAN: begin
        mem_re    = scan_nxt < SLOTS_C;
        mem_raddr = scan_nxt[IDX_W-1:0];
      end
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = first_r ? head_val_r : fill_val_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          ptr_r <= ptr_r + ONE_C;
          if (ptr_r == LAST_C) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_data.cmd == cslot_pkg::CMD_ALLOC) begin
              size_r  <= req_size;
              limit_r <= SLOTS_C + ONE_C - req_size;
              scan_r  <= '0;
              run_r   <= '0;
              if (req_size == '0) begin
                out_r       <= '0;
                out_valid_r <= 1'b1;
              end else begin
                state_r <= S_SCAN;
              end
            end else begin
              ptr_r               <= req_slot;
              res_r.head_slot     <= in_data.slot;
              res_r.forced        <= 1'b0;
              res_r.freed_count   <= '0;
              if (req_slot < SLOTS_C) begin
                state_r <= S_FREE_RD;
              end else begin
                out_r.head_slot   <= in_data.slot;
                out_r.forced      <= 1'b0;
                out_r.freed_count <= '0;
                out_valid_r       <= 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          scan_r      <= scan_nxt;
          first_r     <= 1'b1;
          head_val_r  <= size_r[FW-1:0];
          fill_val_r  <= FW'(1);
          cnt_r       <= size_r;
          res_r.freed_count <= '0;
          if (scan_r >= limit_r) begin
            ptr_r           <= forced_head;
            res_r.head_slot <= forced_head[FW-1:0];
            res_r.forced    <= 1'b1;
            state_r         <= S_WRITE;
          end else if (rd_data_r != '0) begin
            run_r <= scan_nxt;
          end else if (scan_r - run_r == size_r + ONE_C) begin
            ptr_r           <= run_r;
            res_r.head_slot <= run_r[FW-1:0];
            res_r.forced    <= 1'b0;
            state_r         <= S_WRITE;
          end
        end
        S_FREE_RD: begin
          first_r           <= 1'b1;
          head_val_r        <= '0;
          fill_val_r        <= '0;
          cnt_r             <= free_n;
          res_r.freed_count <= free_n[FW-1:0];
          if (free_n == '0) begin
            out_r             <= res_r;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end else begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          first_r <= 1'b0;
          ptr_r   <= ptr_r + ONE_C;
          cnt_r   <= cnt_r - ONE_C;
          if (cnt_r == ONE_C) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_forced_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.forced |-> out_data.freed_count == '0)
    else $error("forced allocate result reports freed entries");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r && busy)
    else $error("activity during the clearing pass");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ptr_r < SLOTS_C)
    else $error("table write beyond the last slot");

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> state_r == S_SCAN || state_r == S_WRITE)
    else $error("scan left without marking a block");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("table read and write in the same cycle");

endmodule
